/* design/nearest_neighbor_image_rotation_assert.svh */
// Assertion shorthands for the rotator; clk and rst are taken from the scope.
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATION_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATION_ASSERT_SVH

// Consequent checked in the same cycle.
`define NNIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define NNIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nnir_pkg.sv */
package nnir_pkg;

  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int COORD_W = 8;
  localparam int PIX_W   = 32;
  localparam int TRIG_W  = 16;
  localparam int DIM_W   = 9;
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = XW + YW;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

  // offset from center, product, sum and mapped coordinate widths
  localparam int XR_W   = COORD_W + 2;
  localparam int PROD_W = TRIG_W + XR_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAP_W  = SUM_W - TRIG_FRAC_BITS;

  localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << TRIG_FRAC_BITS) - 1);

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_COS    = 2'd0,
    CFG_SIN    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                operation;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIX_W-1:0]   pixel_in;
  } req_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             inside_res;
  } rsp_word_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_angle;
    logic signed [TRIG_W-1:0] sin_angle;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
  } cfg_t;

  // mapper result at the memory access stage
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              in_frame;
    logic              store_ok;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
  } map_res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* design/nnir_frame_mem.sv */
module nnir_frame_mem import nnir_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // registered read; holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* design/nnir_map.sv */
module nnir_map import nnir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      req_valid,
  input  req_word_t req,
  input  cfg_t      cfg,
  output map_res_t  res
);

  logic [COORD_W-1:0] cx, cy;
  logic signed [XR_W-1:0] xr_c, yr_c;
  logic dst_in_c;

  assign cx = cfg.width[DIM_W-1:1];
  assign cy = cfg.height[DIM_W-1:1];
  assign xr_c = $signed({2'b00, req.coord_x}) - $signed({2'b00, cx});
  assign yr_c = $signed({2'b00, req.coord_y}) - $signed({2'b00, cy});
  assign dst_in_c = ({1'b0, req.coord_x} < cfg.width) && ({1'b0, req.coord_y} < cfg.height);

  // stage 1: request and offsets from center
  logic v1, dst1;
  op_t op1;
  logic [COORD_W-1:0] x1, y1;
  logic [PIX_W-1:0] pix1;
  logic signed [XR_W-1:0] xr1, yr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= req.operation;
      x1   <= req.coord_x;
      y1   <= req.coord_y;
      pix1 <= req.pixel_in;
      xr1  <= xr_c;
      yr1  <= yr_c;
      dst1 <= dst_in_c;
    end
  end

  // stage 2: four products
  logic v2, dst2;
  op_t op2;
  logic [COORD_W-1:0] x2, y2;
  logic [PIX_W-1:0] pix2;
  logic signed [PROD_W-1:0] p_cx, p_sy, p_sx, p_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2  <= op1;
      x2   <= x1;
      y2   <= y1;
      pix2 <= pix1;
      dst2 <= dst1;
      p_cx <= cfg.cos_angle * xr1;
      p_sy <= cfg.sin_angle * yr1;
      p_sx <= cfg.sin_angle * xr1;
      p_cy <= cfg.cos_angle * yr1;
    end
  end

  // stage 3: rotated sums plus center, still scaled by 2^frac
  logic v3, dst3;
  op_t op3;
  logic [COORD_W-1:0] x3, y3;
  logic [PIX_W-1:0] pix3;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3   <= op2;
      x3    <= x2;
      y3    <= y2;
      pix3  <= pix2;
      dst3  <= dst2;
      sum_x <= SUM_W'(p_cx) + SUM_W'(p_sy) + SUM_W'({cx, {TRIG_FRAC_BITS{1'b0}}});
      sum_y <= SUM_W'(p_cy) - SUM_W'(p_sx) + SUM_W'({cy, {TRIG_FRAC_BITS{1'b0}}});
    end
  end

  // truncate toward zero: bias negatives by 2^frac-1 before the shift
  logic [SUM_W-1:0] adj_x, adj_y;
  logic [MAP_W-1:0] xs, ys;
  logic in_x, in_y;

  always_comb begin
    adj_x = sum_x + (sum_x[SUM_W-1] ? FRAC_MASK : '0);
    adj_y = sum_y + (sum_y[SUM_W-1] ? FRAC_MASK : '0);
    xs = adj_x[SUM_W-1:TRIG_FRAC_BITS];
    ys = adj_y[SUM_W-1:TRIG_FRAC_BITS];
    in_x = !xs[MAP_W-1] && (xs[MAP_W-2:0] < (MAP_W-1)'(cfg.width));
    in_y = !ys[MAP_W-1] && (ys[MAP_W-2:0] < (MAP_W-1)'(cfg.height));
  end

  always_comb begin
    res.valid    = v3;
    res.op       = op3;
    res.in_frame = dst3 && in_x && in_y;
    res.store_ok = (32'(x3) < MAX_WIDTH) && (32'(y3) < MAX_HEIGHT);
    res.pixel    = pix3;
    if (op3 == OP_STORE) begin
      res.addr = {y3[YW-1:0], x3[XW-1:0]};
    end else begin
      res.addr = {ys[YW-1:0], xs[XW-1:0]};
    end
  end

endmodule

/* design/nearest_neighbor_image_rotation.sv */
// Nearest-neighbor rotator over a 256x256 frame of 32-bit ARGB words held in
// one single-port synchronous RAM. A store word (operation 0) writes pixel_in
// at row coord_y, column coord_x and yields no response. A read word
// (operation 1) names a destination pixel; it is mapped back about the frame
// center (width/2, height/2) through the Q1.14 cos_angle/sin_angle registers,
// truncated toward zero, and yields one response word: the source pixel with
// inside_res set, or zero with inside_res clear when the mapped point or the
// destination itself falls outside width x height. Throughput is one word per
// clock while rsp_stall does not freeze the pipeline; the path is a pipeline
// of offsets, multiply, sum, RAM access and response register stages, in that
// order. Stores and reads reach the RAM port at the same pipeline stage and
// in request order, so a read always sees every earlier store. rsp_stall
// while a response is waiting freezes the whole pipeline and is reflected on
// req_stall. Configuration writes are always ready and must be issued only
// while the pipeline is empty; width and height are clamped to 1..256 when
// written. Frame contents are undefined after reset until stored.
module nearest_neighbor_image_rotation import nnir_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_word_t          req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_word_t          rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_idx_t           cfg_index,
  input  logic [TRIG_W-1:0]  cfg_data
);

  `include "nearest_neighbor_image_rotation_assert.svh"

  // config registers; dimensions stored already clamped
  logic signed [TRIG_W-1:0] cos_angle, sin_angle;
  logic [DIM_W-1:0] frame_w, frame_h;
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= TRIG_W'(1 << TRIG_FRAC_BITS);
      sin_angle <= '0;
      frame_w   <= DIM_W'(MAX_WIDTH);
      frame_h   <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COS:    cos_angle <= cfg_data;
        CFG_SIN:    sin_angle <= cfg_data;
        CFG_WIDTH:  frame_w   <= clamp_dim(cfg_data[DIM_W-1:0], MAX_WIDTH);
        CFG_HEIGHT: frame_h   <= clamp_dim(cfg_data[DIM_W-1:0], MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  assign cfg.cos_angle = cos_angle;
  assign cfg.sin_angle = sin_angle;
  assign cfg.width     = frame_w;
  assign cfg.height    = frame_h;

  // global advance: everything moves unless a response is held back
  logic en;
  assign en = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  map_res_t m;

  nnir_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .cfg       (cfg),
    .res       (m)
  );

  logic mem_wr, mem_rd;
  logic [PIX_W-1:0] rdata;

  assign mem_wr = en && m.valid && (m.op == OP_STORE) && m.store_ok;
  assign mem_rd = en && m.valid && (m.op == OP_READ);

  nnir_frame_mem u_mem (
    .clk   (clk),
    .wr_en (mem_wr),
    .rd_en (mem_rd),
    .addr  (m.addr),
    .wdata (m.pixel),
    .rdata (rdata)
  );

  // stage aligned with RAM read data
  logic v4, inside4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= m.valid && (m.op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside4 <= m.in_frame;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.pixel_out  <= inside4 ? rdata : '0;
      rsp.inside_res <= inside4;
    end
  end

  `NNIR_ASSERT_NOW(a_outside_zero, rsp_valid && !rsp.inside_res, rsp.pixel_out == '0,
    "outside response carries a nonzero pixel")
  `NNIR_ASSERT_NOW(a_width_range, 1'b1, (frame_w != '0) && (32'(frame_w) <= MAX_WIDTH),
    "frame width out of range")
  `NNIR_ASSERT_NOW(a_height_range, 1'b1, (frame_h != '0) && (32'(frame_h) <= MAX_HEIGHT),
    "frame height out of range")
  `NNIR_ASSERT_NEXT(a_store_no_rsp, mem_wr, !v4,
    "store word produced a response slot")

endmodule

/* dv/nnir_checker.sv */
// Watches the rotator's channels, predicts each read word and checks responses in order.
module nnir_checker import nnir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  req_word_t         req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  rsp_word_t         rsp,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  cfg_idx_t          cfg_index,
  input  logic [TRIG_W-1:0] cfg_data,
  output int                pending_reads,
  output int                errors
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PIX_W-1:0]         src_frame [DEPTH];
  logic signed [TRIG_W-1:0] rot_cos;
  logic signed [TRIG_W-1:0] rot_sin;
  logic [DIM_W-1:0]         frame_w;
  logic [DIM_W-1:0]         frame_h;
  rsp_word_t                expected_pixels [$];

  initial begin
    errors = 0;
    pending_reads = 0;
  end

  function automatic longint eff_dim(logic [DIM_W-1:0] raw, longint limit);
    longint d;
    d = raw;
    if (d < 1) d = 1;
    if (d > limit) d = limit;
    return d;
  endfunction

  // scale down by 2^TRIG_FRAC_BITS, rounding toward zero
  function automatic longint drop_frac(longint t);
    return (t < 0) ? -((-t) >>> TRIG_FRAC_BITS) : (t >>> TRIG_FRAC_BITS);
  endfunction

  // backward map a destination pixel into the source frame
  function automatic rsp_word_t rotate_lookup(req_word_t w);
    longint wd, ht, px, py, cx, cy, xr, yr, c, s, one, xs, ys;
    rsp_word_t r;
    r = '0;
    wd = eff_dim(frame_w, MAX_WIDTH);
    ht = eff_dim(frame_h, MAX_HEIGHT);
    px = w.coord_x;
    py = w.coord_y;
    if (px >= wd || py >= ht) return r;
    cx = wd / 2;
    cy = ht / 2;
    xr = px - cx;
    yr = py - cy;
    c = rot_cos;
    s = rot_sin;
    one = longint'(1) <<< TRIG_FRAC_BITS;
    xs = drop_frac(c * xr + s * yr + cx * one);
    ys = drop_frac(-s * xr + c * yr + cy * one);
    if (xs >= 0 && xs < wd && ys >= 0 && ys < ht) begin
      r.pixel_out = src_frame[ys * MAX_WIDTH + xs];
      r.inside_res = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("[%0t] mismatch %s: expected %0h got %0h", $time, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    rsp_word_t want;
    if (rst) begin
      rot_cos = 16'sh4000;
      rot_sin = '0;
      frame_w = DIM_W'(MAX_WIDTH);
      frame_h = DIM_W'(MAX_HEIGHT);
      expected_pixels.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("response with none pending", 0, rsp);
        end else begin
          want = expected_pixels.pop_front();
          if (rsp.pixel_out !== want.pixel_out)
            report_mismatch("pixel_out", want.pixel_out, rsp.pixel_out);
          if (rsp.inside_res !== want.inside_res)
            report_mismatch("inside_res", want.inside_res, rsp.inside_res);
        end
      end
      if (req_valid && !req_stall) begin
        if (req.operation == OP_STORE) begin
          src_frame[{req.coord_y, req.coord_x}] = req.pixel_in;
        end else begin
          expected_pixels.push_back(rotate_lookup(req));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COS:    rot_cos = cfg_data;
          CFG_SIN:    rot_sin = cfg_data;
          CFG_WIDTH:  frame_w = cfg_data[DIM_W-1:0];
          CFG_HEIGHT: frame_h = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    pending_reads <= expected_pixels.size();
  end

endmodule

/* dv/tb_nearest_neighbor_image_rotation.sv */
// Stimulus and verdict for the rotator; prediction lives in nnir_checker.
module tb_nearest_neighbor_image_rotation;
  timeunit 1ns;
  timeprecision 1ps;
  import nnir_pkg::*;

  // after the last read answers, leave a margin of unstalled clocks for stores
  localparam int  DRAIN_CYCLES = 8;
  localparam int  PHASE_WORDS  = 90;
  localparam int  HOLD_CYCLES  = 300;
  // side of the seeded square; every multi-row frame stays inside it
  localparam int  FILL_DIM     = 16;
  localparam real PI           = 3.14159265358979323846;

  typedef enum {
    PACE_FULL,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_word_t         req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_word_t         rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_idx_t          cfg_index = CFG_COS;
  logic [TRIG_W-1:0] cfg_data = '0;
  int                pending_reads;
  int                errors;

  // pacing knobs; stall_pct is read by the receiver process, so it moves by NBA
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold = 1'b0;
  // effective frame size, only used to aim coordinates
  int   frame_w = MAX_WIDTH;
  int   frame_h = MAX_HEIGHT;

  always #4 clk = ~clk;

  nearest_neighbor_image_rotation u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nnir_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_reads (pending_reads),
    .errors        (errors)
  );

  // Receiver: random stall, or solid stall while a hold-off is running.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= hold || ($urandom_range(99) < stall_pct);
    end
  end

  // Hard stop in case the block wedges.
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one word; returns at the edge that accepts it. Valid stays up between
  // back-to-back words, so it only drops when a gap is drawn.
  task automatic send_word(input req_word_t w);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic store_pixel(input int x, input int y, input logic [PIX_W-1:0] pix);
    send_word('{operation: OP_STORE, coord_x: COORD_W'(x), coord_y: COORD_W'(y),
                pixel_in: pix});
  endtask

  // pixel_in is don't-care on a read; keep it noisy
  task automatic read_pixel(input int x, input int y);
    send_word('{operation: OP_READ, coord_x: COORD_W'(x), coord_y: COORD_W'(y),
                pixel_in: $urandom()});
  endtask

  // Wait until every read has answered, then let stores clear the pipe.
  task automatic drain();
    int quiet;
    quiet = 0;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    while (quiet < DRAIN_CYCLES) begin
      @(posedge clk);
      if (!rsp_stall) quiet++;
    end
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [TRIG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // All four registers, written only with the pipe empty.
  task automatic set_config(input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s,
                            input logic [TRIG_W-1:0] w, input logic [TRIG_W-1:0] h);
    int wd, ht;
    drain();
    cfg_write(CFG_COS, c);
    cfg_write(CFG_SIN, s);
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
    // only the low 9 bits count; zero reads as 1, oversize saturates
    wd = w[DIM_W-1:0];
    ht = h[DIM_W-1:0];
    frame_w = (wd == 0) ? 1 : (wd > MAX_WIDTH) ? MAX_WIDTH : wd;
    frame_h = (ht == 0) ? 1 : (ht > MAX_HEIGHT) ? MAX_HEIGHT : ht;
  endtask

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL:            begin gap_pct = 0;  stall_pct <= 0;  end
      PACE_SENDER_GAPS:     begin gap_pct = 55; stall_pct <= 0;  end
      PACE_RECEIVER_STALLS: begin gap_pct = 0;  stall_pct <= 55; end
      default:              begin gap_pct = 24; stall_pct <= 24; end
    endcase
  endtask

  // Long receiver hold-off while the sender keeps pushing: the pipe fills and
  // req_stall has to come up.
  task automatic hold_off(input int cycles);
    hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold <= 1'b0;
  endtask

  // One phase: new setting, the frame's far corner plus a destination just off
  // the right edge (when the frame is narrower than the store), then random words.
  task automatic run_phase(input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s,
                           input logic [TRIG_W-1:0] w, input logic [TRIG_W-1:0] h,
                           input pace_t pace, input bit pressure);
    int x, y;
    set_config(c, s, w, h);
    set_pace(pace);
    if (pressure) begin
      fork
        hold_off(HOLD_CYCLES);
      join_none
    end
    read_pixel(frame_w - 1, frame_h - 1);
    read_pixel(frame_w % MAX_WIDTH, frame_h - 1);
    repeat (PHASE_WORDS) begin
      // mostly aim inside the frame; now and then anywhere in the store
      x = ($urandom_range(9) < 8) ? $urandom_range(frame_w - 1) : $urandom_range(255);
      y = ($urandom_range(9) < 8) ? $urandom_range(frame_h - 1) : $urandom_range(255);
      if ($urandom_range(99) < 35) begin
        store_pixel(x, y, $urandom());
      end else begin
        read_pixel(x, y);
      end
    end
  endtask

  initial begin
    logic [TRIG_W-1:0] c, s, w, h;
    int ang;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_pace(PACE_FULL);

    // Seed a square in the top-left corner and the whole top row. Frames below
    // either fit in the square or are a single row, so no read can land on an
    // unwritten entry.
    for (int y = 0; y < FILL_DIM; y++) begin
      for (int x = 0; x < FILL_DIM; x++) begin
        store_pixel(x, y, $urandom());
      end
    end
    for (int x = FILL_DIM; x < MAX_WIDTH; x++) begin
      store_pixel(x, 0, $urandom());
    end

    // Reset setting is identity over 256x256: corners with extreme pixels.
    store_pixel(0, 0, 32'h0000_0000);
    store_pixel(255, 255, 32'hFFFF_FFFF);
    store_pixel(0, 255, 32'hAAAA_5555);
    store_pixel(255, 0, 32'h5555_AAAA);
    read_pixel(0, 0);
    read_pixel(255, 255);
    read_pixel(0, 255);
    read_pixel(255, 0);

    // Directed settings.
    // 90 degrees, square frame, receiver held off for a while
    run_phase(16'h0000, 16'h4000, 16'd16, 16'd16, PACE_FULL, 1'b1);
    // 180 degrees on an odd-sized frame: outside destinations come up often
    run_phase(16'hC000, 16'h0000, 16'd15, 16'd9, PACE_SENDER_GAPS, 1'b0);
    // 270 degrees, single row
    run_phase(16'h0000, 16'hC000, 16'd256, 16'd1, PACE_RECEIVER_STALLS, 1'b0);
    // 45 degrees, zero width and height act as 1x1
    run_phase(16'd11585, 16'd11585, 16'd0, 16'd0, PACE_BOTH, 1'b0);
    // trig beyond +-1.0 at the rails, width above the limit saturates
    run_phase(16'h7FFF, 16'h8000, 16'h01FF, 16'd1, PACE_FULL, 1'b0);
    // both trig at the negative rail; upper data bits of width are dropped
    run_phase(16'h8000, 16'h8000, 16'hFE02, 16'd3, PACE_SENDER_GAPS, 1'b0);
    // identity trig on a square frame
    run_phase(16'h4000, 16'h0000, 16'd16, 16'd16, PACE_RECEIVER_STALLS, 1'b0);

    // Random settings: real angles mostly, raw trig words otherwise.
    for (int p = 0; p < 9; p++) begin
      if ($urandom_range(2) == 0) begin
        c = $urandom_range(16'hFFFF);
        s = $urandom_range(16'hFFFF);
      end else begin
        ang = $urandom_range(359);
        c = TRIG_W'($rtoi($cos(ang * PI / 180.0) * 16384.0));
        s = TRIG_W'($rtoi($sin(ang * PI / 180.0) * 16384.0));
      end
      if ($urandom_range(3) == 0) begin
        // full-width single row; widths past 256 saturate
        w = TRIG_W'($urandom_range(511, 256));
        h = TRIG_W'($urandom_range(1));
      end else begin
        w = TRIG_W'($urandom_range(FILL_DIM));
        h = TRIG_W'($urandom_range(FILL_DIM));
      end
      run_phase(c, s, w, h, pace_t'(p % 4), p == 4);
    end

    drain();
    if (errors == 0 && pending_reads == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/nnir_pkg.sv
design/nnir_frame_mem.sv
design/nnir_map.sv
design/nearest_neighbor_image_rotation.sv
dv/nnir_checker.sv
dv/tb_nearest_neighbor_image_rotation.sv
